// File: src/tcce_pkg.sv
package tcce_pkg;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_MAX_COLUMNS       = 2'd0,
		REG_MAX_ROWS          = 2'd1,
		REG_BACKGROUND_ENABLE = 2'd2,
		REG_CLEAR_LINE_ENABLE = 2'd3
	} cfg_reg_t;

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [6:0] MAX_COLUMNS_RESET = 7'd80;
	localparam logic [4:0] MAX_ROWS_RESET    = 5'd22;

	// glyph table layout
	localparam int GLYPH_TABLE_BYTES = 213624;
	localparam int FALLBACK_OFFSET   = 1536;
	localparam int WIDE_BYTES        = 24;
	localparam int WIDE_BASE         = FALLBACK_OFFSET + WIDE_BYTES;
	localparam int NARROW_BYTES      = 12;
	localparam int GB_ROW_CELLS      = 94;
	localparam logic [7:0] GB_LO     = 8'hA1;
	localparam logic [7:0] GB_HI     = 8'hFE;
	localparam int SPACE_OFFSET      = 32 * NARROW_BYTES;
	localparam int TAB_SPACES        = 5;
	localparam int CELL_W            = 6;
	localparam int CELL_H            = 12;

	// control bytes
	localparam logic [7:0] CHAR_TAB = 8'h09;
	localparam logic [7:0] CHAR_LF  = 8'h0A;
	localparam logic [7:0] CHAR_CR  = 8'h0D;

	localparam int JOB_DEPTH_DEFAULT = 4;
	localparam int OUT_DEPTH         = 2;

	typedef struct packed {
		logic       mode;
		logic [7:0] data_byte;
		logic       end_of_buffer;
		logic [6:0] new_column;
		logic [4:0] new_row;
	} in_item_t;

	typedef struct packed {
		logic        command_kind;
		logic [8:0]  pixel_x;
		logic [8:0]  pixel_y;
		logic [17:0] glyph_offset;
		logic        glyph_wide;
		logic        use_background_color;
		logic        last;
	} out_cmd_t;

	typedef struct packed {
		logic [6:0] max_columns;
		logic [4:0] max_rows;
		logic       background_enable;
		logic       clear_line_enable;
	} cfg_t;

	// work handed from front to back: optional row clear, then ndraw glyphs
	typedef struct packed {
		logic        clear;
		logic [2:0]  ndraw;
		logic [6:0]  column;
		logic [4:0]  row;
		logic [17:0] glyph_offset;
		logic        wide;
	} job_t;

endpackage

// File: src/tcce_fifo.sv
module tcce_fifo
	import tcce_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// File: src/tcce_front.sv
module tcce_front
	import tcce_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     push,
	input  in_item_t item,
	output logic     full,
	output logic     job_push,
	output job_t     job,
	input  logic     job_full
);

	logic [6:0] col_q, col_d;
	logic [4:0] row_q, row_d;
	logic       pend_q, pend_d;
	logic [7:0] lead_q, lead_d;

	logic        accept, want_job, clear_en;
	logic [7:0]  c1, c2;
	logic        gb_ok;
	logic [6:0]  d1, d2;
	logic [13:0] idx;
	logic [18:0] wide_off;
	logic [17:0] wide_sel;
	logic [5:0]  row_inc;
	logic [4:0]  nrow;
	logic        is_wide;
	logic [7:0]  col_need;
	logic        wrap;
	logic [6:0]  col_at;
	logic [6:0]  room;
	logic [2:0]  tab_n;

	assign full     = job_full;
	assign accept   = push && !job_full;
	assign job_push = accept && want_job;
	assign clear_en = cfg.clear_line_enable && cfg.background_enable;

	// double-byte glyph offset from gb2312 row and cell
	assign c1    = pend_q ? lead_q : item.data_byte;
	assign c2    = pend_q ? item.data_byte : 8'd0;
	assign gb_ok = (c1 >= GB_LO) && (c1 <= GB_HI) && (c2 >= GB_LO) && (c2 <= GB_HI);
	assign d1    = 7'(c1 - GB_LO);
	assign d2    = 7'(c2 - GB_LO);
	assign idx   = 14'(d1) * 14'(GB_ROW_CELLS) + 14'(d2);
	assign wide_off = gb_ok ? (19'(WIDE_BASE) + 19'(idx) * 19'(WIDE_BYTES))
	                        : 19'(FALLBACK_OFFSET);
	assign wide_sel = ((wide_off + 19'(WIDE_BYTES)) > 19'(GLYPH_TABLE_BYTES))
	                  ? 18'(FALLBACK_OFFSET) : wide_off[17:0];

	// row after a line advance
	assign row_inc = {1'b0, row_q} + 6'd1;
	assign nrow    = (row_inc >= {1'b0, cfg.max_rows}) ? 5'd0 : row_inc[4:0];

	// line wrap ahead of a glyph
	assign is_wide  = pend_q || item.data_byte[7];
	assign col_need = {1'b0, col_q} + (is_wide ? 8'd2 : 8'd1);
	assign wrap     = col_need > {1'b0, cfg.max_columns};
	assign col_at   = wrap ? 7'd0 : col_q;

	// tab run length
	assign room  = cfg.max_columns - col_q;
	assign tab_n = (room > 7'(TAB_SPACES)) ? 3'(TAB_SPACES) : room[2:0];

	always_comb begin
		col_d    = col_q;
		row_d    = row_q;
		pend_d   = pend_q;
		lead_d   = lead_q;
		want_job = 1'b0;
		job      = '0;
		if (item.mode) begin
			if (item.new_column < cfg.max_columns) begin
				col_d = item.new_column;
			end
			if (item.new_row < cfg.max_rows) begin
				row_d = item.new_row;
			end
		end else if (pend_q || (item.data_byte[7] && item.end_of_buffer)) begin
			pend_d           = 1'b0;
			want_job         = 1'b1;
			job.clear        = wrap && clear_en;
			job.ndraw        = 3'd1;
			job.column       = col_at;
			job.row          = wrap ? nrow : row_q;
			job.glyph_offset = wide_sel;
			job.wide         = 1'b1;
			col_d            = col_at + 7'd2;
			row_d            = job.row;
		end else if (item.data_byte[7]) begin
			pend_d = 1'b1;
			lead_d = item.data_byte;
		end else begin
			case (item.data_byte)
				CHAR_CR: begin
					col_d = '0;
				end
				CHAR_LF: begin
					col_d     = '0;
					row_d     = nrow;
					want_job  = clear_en;
					job.clear = 1'b1;
					job.row   = nrow;
				end
				CHAR_TAB: begin
					if (col_q < cfg.max_columns) begin
						want_job         = 1'b1;
						job.ndraw        = tab_n;
						job.column       = col_q;
						job.row          = row_q;
						job.glyph_offset = 18'(SPACE_OFFSET);
						col_d            = col_q + 7'(tab_n);
					end
				end
				default: begin
					want_job         = 1'b1;
					job.clear        = wrap && clear_en;
					job.ndraw        = 3'd1;
					job.column       = col_at;
					job.row          = wrap ? nrow : row_q;
					job.glyph_offset = 18'(item.data_byte) * 18'(NARROW_BYTES);
					col_d            = col_at + 7'd1;
					row_d            = job.row;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= 1'b0;
			lead_q <= '0;
		end else if (accept) begin
			col_q  <= col_d;
			row_q  <= row_d;
			pend_q <= pend_d;
			lead_q <= lead_d;
		end
	end

endmodule

// File: src/tcce_back.sv
module tcce_back
	import tcce_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  job_t     job,
	input  logic     job_empty,
	output logic     job_pop,
	output out_cmd_t result,
	output logic     empty,
	input  logic     pop
);

	logic [2:0] step_q;
	logic [2:0] total, j;
	logic [7:0] col;
	logic       out_full, issue, final_step;
	out_cmd_t   cmd;

	assign total      = 3'(job.clear) + job.ndraw;
	assign final_step = (step_q == total - 3'd1);
	assign issue      = !job_empty && !out_full;
	assign job_pop    = issue && final_step;
	assign j          = step_q - 3'(job.clear);
	assign col        = {1'b0, job.column} + {5'b0, j};

	always_comb begin
		cmd         = '0;
		cmd.pixel_y = 9'(job.row) * 9'(CELL_H);
		cmd.last    = final_step;
		if (job.clear && (step_q == 3'd0)) begin
			cmd.command_kind         = 1'b1;
			cmd.use_background_color = 1'b1;
		end else begin
			cmd.pixel_x      = {1'b0, col} * 9'(CELL_W);
			cmd.glyph_offset = job.glyph_offset;
			cmd.glyph_wide   = job.wide;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (issue) begin
			step_q <= final_step ? 3'd0 : step_q + 3'd1;
		end
	end

	tcce_fifo #(
		.WIDTH($bits(out_cmd_t)),
		.DEPTH(OUT_DEPTH)
	) u_out_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (issue),
		.wdata (cmd),
		.full  (out_full),
		.pop   (pop),
		.rdata (result),
		.empty (empty)
	);

endmodule

// File: src/text_console_cursor_engine_top.sv
// path: a drawing byte enters the job queue with its input transfer; the command generator
// moves its commands into the result queue, which drives the result ports
// throughput: one input byte per cycle while the job queue has room; the command generator emits
// one command per cycle while it holds a job and the result queue has room; a byte giving several
// commands (tab up to five, wrap adds a row clear) is a burst that the job queue absorbs
// reset: arst_n low clears cursor, pending lead byte and queues, and loads register defaults
module text_console_cursor_engine_top
	import tcce_pkg::*;
#(
	parameter int JOB_DEPTH = JOB_DEPTH_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration writes
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// input side, one transfer per byte or set-cursor request
	input  logic                  push,
	input  in_item_t              item,
	output logic                  full,
	// result side, one transfer per draw or row-clear command
	output out_cmd_t              result,
	output logic                  empty,
	input  logic                  pop
);

	cfg_t cfg_q;
	job_t job_in, job_out;
	logic job_push, job_full, job_pop, job_empty;

	// register file; the user must write it only while the block is idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_columns       <= MAX_COLUMNS_RESET;
			cfg_q.max_rows          <= MAX_ROWS_RESET;
			cfg_q.background_enable <= 1'b1;
			cfg_q.clear_line_enable <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_addr))
				REG_MAX_COLUMNS:       cfg_q.max_columns       <= cfg_wdata;
				REG_MAX_ROWS:          cfg_q.max_rows          <= cfg_wdata[4:0];
				REG_BACKGROUND_ENABLE: cfg_q.background_enable <= cfg_wdata[0];
				REG_CLEAR_LINE_ENABLE: cfg_q.clear_line_enable <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// front: cursor tracking, lead byte pairing, wrap decision, glyph offset
	tcce_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.push    (push),
		.item    (item),
		.full    (full),
		.job_push(job_push),
		.job     (job_in),
		.job_full(job_full)
	);

	// short queue so the front keeps taking bytes during a tab burst
	tcce_fifo #(
		.WIDTH($bits(job_t)),
		.DEPTH(JOB_DEPTH)
	) u_job_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (job_push),
		.wdata (job_in),
		.full  (job_full),
		.pop   (job_pop),
		.rdata (job_out),
		.empty (job_empty)
	);

	// back: expands each job into commands, one per cycle while the result queue has room, marks the last
	tcce_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (job_out),
		.job_empty(job_empty),
		.job_pop  (job_pop),
		.result   (result),
		.empty    (empty),
		.pop      (pop)
	);

`ifndef SYNTH
	// a job only retires when one is present
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> !job_empty)
		else $error("job retired from empty queue");

	// work enters the queue only with an accepted input transfer
	a_push_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		job_push |-> (push && !full))
		else $error("job queued without input transfer");

	// a set-cursor request never yields commands
	a_setcursor_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && item.mode) |-> !job_push)
		else $error("set cursor produced a job");
`endif

endmodule

// File: tb/tcce_scoreboard_pkg.sv
package tcce_scoreboard_pkg;
	import tcce_pkg::*;

	localparam logic MODE_TEXT       = 1'b0;
	localparam logic MODE_SET_CURSOR = 1'b1;
	localparam logic KIND_DRAW       = 1'b0;
	localparam logic KIND_CLEAR_ROW  = 1'b1;
	localparam logic [7:0] NO_TRAIL  = 8'h00;

	class console_scoreboard;
		logic [6:0] max_cols;
		logic [4:0] max_rows;
		logic       bg_en;
		logic       clr_en;
		logic [6:0] col;
		logic [4:0] row;
		logic       lead_held;
		logic [7:0] lead;
		out_cmd_t   pending_cmds[$];
		out_cmd_t   burst[$];
		int         errors;

		function new();
			max_cols  = MAX_COLUMNS_RESET;
			max_rows  = MAX_ROWS_RESET;
			bg_en     = 1'b1;
			clr_en    = 1'b1;
			col       = '0;
			row       = '0;
			lead_held = 1'b0;
			lead      = '0;
			errors    = 0;
		endfunction

		function void write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_MAX_COLUMNS:       max_cols = value[6:0];
				REG_MAX_ROWS:          max_rows = value[4:0];
				REG_BACKGROUND_ENABLE: bg_en    = value[0];
				REG_CLEAR_LINE_ENABLE: clr_en   = value[0];
				default: ;
			endcase
		endfunction

		function void emit(logic kind, int x_col, int y_row, int offset, logic wide,
			logic bg);
			out_cmd_t c;
			int px;
			int py;
			px = x_col * CELL_W;
			py = y_row * CELL_H;
			c.command_kind         = kind;
			c.pixel_x              = px[8:0];
			c.pixel_y              = py[8:0];
			c.glyph_offset         = offset[17:0];
			c.glyph_wide           = wide;
			c.use_background_color = bg;
			c.last                 = 1'b0;
			burst.push_back(c);
		endfunction

		function void new_line();
			int r;
			col = '0;
			r = int'(row) + 1;
			if (r >= int'(max_rows))
				r = 0;
			row = r[4:0];
			if (clr_en && bg_en)
				emit(KIND_CLEAR_ROW, 0, int'(row), 0, 1'b0, 1'b1);
		endfunction

		function void draw_glyph(int offset, logic wide);
			emit(KIND_DRAW, int'(col), int'(row), offset, wide, 1'b0);
		endfunction

		function void wide_glyph(logic [7:0] c1, logic [7:0] c2);
			int offset;
			offset = FALLBACK_OFFSET;
			if (c1 >= GB_LO && c1 <= GB_HI && c2 >= GB_LO && c2 <= GB_HI)
				offset = WIDE_BASE + (GB_ROW_CELLS * (int'(c1) - int'(GB_LO))
					+ (int'(c2) - int'(GB_LO))) * WIDE_BYTES;
			if (offset + WIDE_BYTES > GLYPH_TABLE_BYTES)
				offset = FALLBACK_OFFSET;
			if (int'(col) + 2 > int'(max_cols))
				new_line();
			draw_glyph(offset, 1'b1);
			col = col + 7'd2;
		endfunction

		// works out the commands one accepted input causes
		function void note_item(in_item_t it);
			out_cmd_t c;
			int j;
			burst.delete();
			if (it.mode == MODE_SET_CURSOR) begin
				if (it.new_column < max_cols)
					col = it.new_column;
				if (it.new_row < max_rows)
					row = it.new_row;
			end else if (lead_held) begin
				lead_held = 1'b0;
				wide_glyph(lead, it.data_byte);
			end else if (it.data_byte[7]) begin
				if (it.end_of_buffer) begin
					wide_glyph(it.data_byte, NO_TRAIL);
				end else begin
					lead_held = 1'b1;
					lead = it.data_byte;
				end
			end else if (it.data_byte == CHAR_CR) begin
				col = '0;
			end else if (it.data_byte == CHAR_LF) begin
				new_line();
			end else if (it.data_byte == CHAR_TAB) begin
				for (j = 0; j < TAB_SPACES && col < max_cols; j++) begin
					draw_glyph(SPACE_OFFSET, 1'b0);
					col = col + 7'd1;
				end
			end else begin
				if (int'(col) + 1 > int'(max_cols))
					new_line();
				draw_glyph(int'(it.data_byte) * NARROW_BYTES, 1'b0);
				col = col + 7'd1;
			end
			foreach (burst[i]) begin
				c = burst[i];
				c.last = (i == burst.size() - 1);
				pending_cmds.push_back(c);
			end
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_command(out_cmd_t got);
			out_cmd_t want;
			if (pending_cmds.size() == 0) begin
				$error("command with none expected: kind %0d x %0d y %0d offset %0d",
					got.command_kind, got.pixel_x, got.pixel_y, got.glyph_offset);
				errors++;
				return;
			end
			want = pending_cmds.pop_front();
			check_field("command_kind", want.command_kind, got.command_kind);
			check_field("pixel_x", want.pixel_x, got.pixel_x);
			check_field("pixel_y", want.pixel_y, got.pixel_y);
			check_field("glyph_offset", want.glyph_offset, got.glyph_offset);
			check_field("glyph_wide", want.glyph_wide, got.glyph_wide);
			check_field("use_background_color", want.use_background_color,
				got.use_background_color);
			check_field("last", want.last, got.last);
		endfunction

		function void check_drained();
			if (pending_cmds.size() != 0) begin
				$error("%0d expected commands never arrived", pending_cmds.size());
				errors++;
			end
		endfunction
	endclass

endpackage

// File: tb/text_console_cursor_engine_top_test.sv
module text_console_cursor_engine_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import tcce_pkg::*;
	import tcce_scoreboard_pkg::*;

	// worst case is far below this: ~520 inputs, up to 5 commands each, with idle and stall gaps
	localparam int CYCLE_LIMIT  = 400000;
	// quiet time after the last expected command, well past the path through both queues
	localparam int DRAIN_CYCLES = 12;
	localparam int PHASE_UNITS  = 70;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  push;
	in_item_t              item;
	logic                  full;
	out_cmd_t              result;
	logic                  empty;
	logic                  pop;

	console_scoreboard sb = new();

	// chance in percent of an idle burst before an input / of a pop stall per cycle
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned cycle_count = 0;

	// current limits, used to aim set-cursor requests in range
	logic [6:0] cur_cols = MAX_COLUMNS_RESET;
	logic [4:0] cur_rows = MAX_ROWS_RESET;

	text_console_cursor_engine_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.item      (item),
		.full      (full),
		.result    (result),
		.empty     (empty),
		.pop       (pop)
	);

	always #6 clk = ~clk;

	// timeout watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// watch both sides: every transfer in feeds the predictor, every transfer out is checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				sb.note_item(item);
			if (pop && !empty)
				sb.check_command(result);
		end
	end

	// result side: pop mostly high, with random stall bursts
	initial begin
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end
			pop <= 1'b1;
		end
	end

	// one input transfer, possibly after an idle burst; returns at the accepting edge
	task automatic send_item(input in_item_t it);
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	// text byte; the set-cursor fields carry noise
	function automatic in_item_t text_item(logic [7:0] b, logic eob);
		in_item_t it;
		it.mode          = MODE_TEXT;
		it.data_byte     = b;
		it.end_of_buffer = eob;
		it.new_column    = 7'($urandom);
		it.new_row       = 5'($urandom);
		return it;
	endfunction

	// set-cursor request; the text fields carry noise
	function automatic in_item_t cursor_item(logic [6:0] c, logic [4:0] r);
		in_item_t it;
		it.mode          = MODE_SET_CURSOR;
		it.data_byte     = 8'($urandom);
		it.end_of_buffer = 1'($urandom);
		it.new_column    = c;
		it.new_row       = r;
		return it;
	endfunction

	// wait for every expected command, then let the block go quiet
	task automatic settle();
		@(posedge clk);
		while (sb.pending_cmds.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// all four registers in one burst of writes, only while the block is idle
	task automatic write_config(input logic [6:0] cols, input logic [4:0] rows,
		input logic bg, input logic clr);
		cfg_reg_t order[4];
		logic [CFG_DATA_W-1:0] value;
		order = '{REG_MAX_COLUMNS, REG_MAX_ROWS, REG_BACKGROUND_ENABLE, REG_CLEAR_LINE_ENABLE};
		cfg_we <= 1'b1;
		foreach (order[i]) begin
			case (order[i])
				REG_MAX_COLUMNS:       value = CFG_DATA_W'(cols);
				REG_MAX_ROWS:          value = CFG_DATA_W'(rows);
				REG_BACKGROUND_ENABLE: value = CFG_DATA_W'(bg);
				default:               value = CFG_DATA_W'(clr);
			endcase
			cfg_addr <= order[i];
			cfg_wdata <= value;
			@(posedge clk);
			sb.write_register(order[i], value);
		end
		cfg_we <= 1'b0;
		cur_cols = cols;
		cur_rows = rows;
	endtask

	// mostly well-formed text: printable runs, control bytes, double-byte pairs,
	// cursor moves; the rest is stray lead bytes and raw noise
	task automatic send_random_unit(output int sent);
		in_item_t it;
		logic [31:0] noise;
		int unsigned pick;
		noise = $urandom;
		it = text_item(8'($urandom), 1'b0);
		sent = 1;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			it = cursor_item(7'($urandom), 5'($urandom));
			// half of the requests are aimed at the current limits, the limits themselves included
			if (noise[30]) begin
				it.new_column = 7'($urandom_range(0, cur_cols));
				it.new_row = 5'($urandom_range(0, cur_rows));
			end
		end else if (pick < 38) begin
			it.data_byte = 8'($urandom_range(8'h20, 8'h7E));
		end else if (pick < 43) begin
			it.data_byte = CHAR_CR;
		end else if (pick < 51) begin
			it.data_byte = CHAR_LF;
		end else if (pick < 58) begin
			it.data_byte = CHAR_TAB;
		end else if (pick < 83) begin
			// double-byte pair inside the code table
			it.data_byte = 8'($urandom_range(GB_LO, GB_HI));
			send_item(it);
			it.data_byte = 8'($urandom_range(GB_LO, GB_HI));
			it.end_of_buffer = noise[29];
			sent = 2;
		end else if (pick < 90) begin
			// lone lead byte at the end of a buffer
			it.data_byte = 8'($urandom_range(8'h80, 8'hFF));
			it.end_of_buffer = 1'b1;
		end else begin
			it.end_of_buffer = noise[28];
		end
		send_item(it);
	endtask

	task automatic run_phase(input logic [6:0] cols, input logic [4:0] rows,
		input logic bg, input logic clr, input int unsigned idle_level);
		int sent;
		int n;
		settle();
		write_config(cols, rows, bg, clr);
		idle_pct = idle_level;
		stall_pct = idle_level;
		n = 0;
		while (n < PHASE_UNITS) begin
			send_random_unit(sent);
			n += sent;
		end
		push <= 1'b0;
	endtask

	// register defaults: extremes of the fields, every control byte, the special cases
	task automatic run_directed();
		idle_pct = 15;
		stall_pct = 15;
		send_item(text_item(8'h00, 1'b1));
		send_item(text_item(8'h7F, 1'b0));
		send_item(text_item(CHAR_TAB, 1'b0));
		send_item(text_item(CHAR_CR, 1'b0));
		send_item(text_item(CHAR_LF, 1'b0));
		// lowest and highest table entries
		send_item(text_item(GB_LO, 1'b0));
		send_item(text_item(GB_LO, 1'b0));
		send_item(text_item(GB_HI, 1'b0));
		send_item(text_item(GB_HI, 1'b0));
		// lead outside the table gives the fallback glyph
		send_item(text_item(8'h80, 1'b0));
		send_item(text_item(8'h41, 1'b0));
		// a control byte after a lead is a trail byte, end of buffer ignored
		send_item(text_item(8'hB0, 1'b0));
		send_item(text_item(CHAR_CR, 1'b1));
		// lone lead at end of buffer pairs with a zero trail
		send_item(text_item(8'hFF, 1'b1));
		// lead stays pending across a cursor move
		send_item(text_item(8'hC0, 1'b0));
		send_item(cursor_item(7'd10, 5'd5));
		send_item(text_item(8'hC1, 1'b0));
		// both coordinates out of range: ignored
		send_item(cursor_item(7'd127, 5'd31));
		// last cell fits a narrow glyph, then a wide one wraps past the bottom row
		send_item(cursor_item(7'd79, 5'd21));
		send_item(text_item(8'h78, 1'b0));
		send_item(text_item(GB_LO, 1'b0));
		send_item(text_item(8'hB0, 1'b0));
		// tab cut short by the row end, then a tab with no room at all
		send_item(cursor_item(7'd77, 5'd3));
		send_item(text_item(CHAR_TAB, 1'b0));
		send_item(text_item(CHAR_TAB, 1'b0));
		push <= 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_addr <= REG_MAX_COLUMNS;
		cfg_wdata <= '0;
		push <= 1'b0;
		item <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		run_directed();
		run_phase(7'd80, 5'd22, 1'b1, 1'b1, 20);
		// single cell screen, row clears gated off by the background
		run_phase(7'd1, 5'd1, 1'b0, 1'b1, 10);
		// largest limits: pixel_x wraps past 511
		run_phase(7'd127, 5'd31, 1'b1, 1'b0, 35);
		// zero limits, entered with the cursor far out of range
		run_phase(7'd0, 5'd0, 1'b1, 1'b1, 5);
		// a stretch with no idling at all
		run_phase(7'd7, 5'd3, 1'b1, 1'b1, 0);
		run_phase(7'($urandom_range(0, 127)), 5'($urandom_range(0, 31)),
			1'($urandom), 1'($urandom), 15);
		// last part of the run runs flat out
		run_phase(7'd80, 5'd22, 1'b1, 1'b1, 0);

		settle();
		sb.check_drained();
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
